[rtl/hgid_pkg.sv]
// Shared constants, types and control structs of the group id assigner.
package hgid_pkg;

	localparam int SLOTS       = 1024;
	localparam int MAX_GROUPS  = 512;
	localparam int KEY_WIDTH   = 64;
	localparam int SLOT_W      = $clog2(SLOTS);
	localparam int GID_W       = 9;
	localparam int CNT_W       = 10;
	localparam int KEY_FIELD_W = 64;
	localparam int HASH_W      = 64;
	localparam int GROW_LIMIT  = (MAX_GROUPS < SLOTS / 2) ? MAX_GROUPS : SLOTS / 2;
	localparam int IN_DATA_W   = 144;
	localparam int OUT_DATA_W  = 88;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_SLOT,
		ST_KEY,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		RES_HIT,
		RES_NEW,
		RES_FULL,
		RES_READ,
		RES_NOGRP
	} res_kind_t;

	typedef struct packed {
		logic            valid;
		logic [HASH_W-1:0] hash;
		logic [GID_W-1:0]  grp;
	} slot_ent_t;

	typedef struct packed {
		logic      clr;
		logic      accept;
		logic      step;
		logic      key_rd;
		logic      emit;
		res_kind_t kind;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic no_grp;
		logic slot_valid;
		logic hash_eq;
		logic key_eq;
		logic last_step;
		logic can_grow;
		logic out_free;
	} dp_stat_t;

endpackage

[rtl/hgid_ctrl.sv]
// Controller state machine: clearing pass, probe walk sequencing and result hand-off.
module hgid_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_action,
	output logic             in_ready,
	input  hgid_pkg::dp_stat_t stat,
	output hgid_pkg::dp_cmd_t  cmd
);
	import hgid_pkg::*;

	state_t    state_q, state_d;
	res_kind_t kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			kind_q  <= RES_HIT;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.kind = kind_q;
		unique case (state_q)
			ST_CLR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (in_action) begin
						kind_d  = RES_READ;
						state_d = ST_EMIT;
					end else if (stat.no_grp) begin
						kind_d  = RES_NOGRP;
						state_d = ST_EMIT;
					end else begin
						state_d = ST_SLOT;
					end
				end
			end
			ST_SLOT: begin
				if (!stat.slot_valid) begin
					kind_d  = stat.can_grow ? RES_NEW : RES_FULL;
					state_d = ST_EMIT;
				end else if (stat.hash_eq) begin
					cmd.key_rd = 1'b1;
					state_d    = ST_KEY;
				end else if (stat.last_step) begin
					kind_d  = RES_FULL;
					state_d = ST_EMIT;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_KEY: begin
				if (stat.key_eq) begin
					kind_d  = RES_HIT;
					state_d = ST_EMIT;
				end else if (stat.last_step) begin
					kind_d  = RES_FULL;
					state_d = ST_EMIT;
				end else begin
					cmd.step = 1'b1;
					state_d  = ST_SLOT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_CLR;
		endcase
	end

`ifndef SYNTHESIS
	a_emit_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> state_q == ST_IDLE)
		else $error("emit not followed by idle");
	a_key_after_hash: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_KEY |-> $past(state_q) == ST_SLOT && $past(stat.hash_eq))
		else $error("key check without hash match");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr, cmd.accept, cmd.step, cmd.key_rd, cmd.emit}))
		else $error("conflicting datapath commands");
`endif

endmodule

[rtl/hgid_dp.sv]
// Datapath: slot and key memories, walk registers, group counter and output register.
module hgid_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  hgid_pkg::dp_cmd_t                cmd,
	output hgid_pkg::dp_stat_t               stat,
	input  logic                             cfg_valid,
	input  logic                             cfg_data,
	input  logic [hgid_pkg::KEY_FIELD_W-1:0] in_key,
	input  logic [hgid_pkg::HASH_W-1:0]      in_hash,
	input  logic [hgid_pkg::GID_W-1:0]       in_gidx,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [hgid_pkg::OUT_DATA_W-1:0]  out_data
);
	import hgid_pkg::*;

	slot_ent_t            slot_mem [SLOTS];
	logic [KEY_WIDTH-1:0] key_mem  [MAX_GROUPS];

	slot_ent_t            slot_rd_q;
	logic [KEY_WIDTH-1:0] key_rd_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [HASH_W-1:0]    hash_q;
	logic [GID_W-1:0]     gidx_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [SLOT_W-1:0]    steps_q;
	logic [SLOT_W-1:0]    clr_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 no_grp_q;
	logic                 out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic                 slot_re, slot_we, key_re, key_we, is_new_ev;
	logic [SLOT_W-1:0]    slot_raddr, slot_waddr;
	slot_ent_t            slot_wdata;
	logic [GID_W-1:0]     key_raddr;
	logic [GID_W-1:0]     res_gid;
	logic                 res_new, res_full;
	logic [CNT_W-1:0]     res_total;
	logic [KEY_FIELD_W-1:0] res_key;

	assign is_new_ev  = cmd.emit && (cmd.kind == RES_NEW);
	assign slot_re    = cmd.accept || cmd.step;
	assign slot_raddr = cmd.accept ? in_hash[SLOT_W-1:0] : slot_q + 1'b1;
	assign slot_we    = cmd.clr || is_new_ev;
	assign slot_waddr = cmd.clr ? clr_q : slot_q;
	assign key_re     = cmd.accept || cmd.key_rd;
	assign key_raddr  = cmd.accept ? in_gidx : slot_rd_q.grp;
	assign key_we     = is_new_ev;

	always_comb begin
		slot_wdata = '0;
		if (!cmd.clr) begin
			slot_wdata.valid = 1'b1;
			slot_wdata.hash  = hash_q;
			slot_wdata.grp   = cnt_q[GID_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (slot_we)
			slot_mem[slot_waddr] <= slot_wdata;
		if (slot_re)
			slot_rd_q <= slot_mem[slot_raddr];
	end

	always_ff @(posedge clk) begin
		if (key_we)
			key_mem[cnt_q[GID_W-1:0]] <= key_q;
		if (key_re)
			key_rd_q <= key_mem[key_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q  <= in_key[KEY_WIDTH-1:0];
			hash_q <= in_hash;
			gidx_q <= in_gidx;
		end
		if (cmd.emit)
			out_data_q <= {3'b000, res_key, res_total, res_full, res_new, res_gid};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			steps_q     <= '0;
			clr_q       <= '0;
			cnt_q       <= '0;
			no_grp_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid)
				no_grp_q <= cfg_data;
			if (cmd.clr)
				clr_q <= clr_q + 1'b1;
			if (cmd.accept) begin
				slot_q  <= in_hash[SLOT_W-1:0];
				steps_q <= '0;
			end else if (cmd.step) begin
				slot_q  <= slot_q + 1'b1;
				steps_q <= steps_q + 1'b1;
			end
			if (is_new_ev)
				cnt_q <= cnt_q + 1'b1;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		res_gid   = '0;
		res_new   = 1'b0;
		res_full  = 1'b0;
		res_total = cnt_q;
		res_key   = '0;
		unique case (cmd.kind)
			RES_HIT:  res_gid = slot_rd_q.grp;
			RES_NEW: begin
				res_gid   = cnt_q[GID_W-1:0];
				res_new   = 1'b1;
				res_total = cnt_q + 1'b1;
			end
			RES_FULL: res_full = 1'b1;
			RES_READ: begin
				res_gid = gidx_q;
				if ({1'b0, gidx_q} < cnt_q)
					res_key = KEY_FIELD_W'(key_rd_q);
			end
			RES_NOGRP: res_total = CNT_W'(1);
			default: res_gid = '0;
		endcase
	end

	assign stat.clr_last   = (clr_q == SLOT_W'(SLOTS - 1));
	assign stat.no_grp     = no_grp_q;
	assign stat.slot_valid = slot_rd_q.valid;
	assign stat.hash_eq    = (slot_rd_q.hash == hash_q);
	assign stat.key_eq     = (key_rd_q == key_q);
	assign stat.last_step  = (steps_q == SLOT_W'(SLOTS - 1));
	assign stat.can_grow   = (cnt_q < CNT_W'(GROW_LIMIT));
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(GROW_LIMIT))
		else $error("group count above capacity");
	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		is_new_ev |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("new group did not advance count");
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!is_new_ev |=> $stable(cnt_q))
		else $error("group count changed without insert");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result overwrote a pending beat");
`endif

endmodule

[rtl/hash_group_id_assigner_top.sv]
// Top level of the group id assigner: stream ports, config port, controller and datapath.
// Usage:
//  s_axis carries one row beat: tuser[0] is the action (0 probe/insert, 1 key read),
//  tdata holds key_value, hash_value and group_index. m_axis returns one beat per row:
//  group_id, is_new, table_full, group_total and key_out.
//  cfg_valid/cfg_data write the no_grouping bit; cfg_ready is always high.
// After reset all 1024 slots of the table are swept clear; s_axis_tready stays
//  low until the sweep is done.
// A read or no-grouping row goes from accept straight to the emit state.
//  A probe reads one slot for each slot visited on the probe chain, plus a key
//  store read for each slot whose stored hash matches. Rows are handled one
//  at a time; the next row can be accepted once a result enters the output
//  register, even while that result waits on m_axis_tready.
// The probe walk through the single-port slot memory sets the rate at which rows
//  are handled.
// When the receiver stalls, the result holds in the output register and the
//  following row is worked up to its result, which then waits for the register.
module hash_group_id_assigner_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// key_value[63:0], hash_value[127:64], group_index[136:128], zero fill
	input  logic [hgid_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// action[0]
	input  logic [0:0]                      s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// group_id[8:0], is_new[9], table_full[10], group_total[20:11], key_out[84:21], zero fill
	output logic [hgid_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_data
);
	import hgid_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	hgid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_action (s_axis_tuser[0]),
		.in_ready  (s_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	hgid_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_key    (s_axis_tdata[KEY_FIELD_W-1:0]),
		.in_hash   (s_axis_tdata[KEY_FIELD_W+HASH_W-1:KEY_FIELD_W]),
		.in_gidx   (s_axis_tdata[KEY_FIELD_W+HASH_W+GID_W-1:KEY_FIELD_W+HASH_W]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
